FILE: sv/ssf_pkg.sv
package ssf_pkg;

    localparam int STATES      = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int STATE_BITS  = 48;

    localparam int TABLE_SIZE = STATES * STATES + 3 * STATES + 1;
    localparam int FRAC_SHIFT = COEF_BITS - 4;
    localparam int HALF_BITS  = STATE_BITS / 2;
    localparam int OPND_BITS  = ((HALF_BITS > SAMPLE_BITS) ? HALF_BITS : SAMPLE_BITS) + 1;
    localparam int PROD_BITS  = COEF_BITS + OPND_BITS;
    localparam int ACC_BITS   = PROD_BITS + HALF_BITS + 4;
    localparam int SH_BITS    = ACC_BITS - FRAC_SHIFT;
    localparam int ROW_BITS   = (STATES > 1) ? $clog2(STATES) : 1;

    localparam int OP_BITS       = 2;
    localparam int CIDX_BITS     = 5;
    localparam int CVAL_BITS     = 32;
    localparam int INIT_BITS     = 24;
    localparam int ACT_BITS      = 3;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [ACT_BITS-1:0]     ACT_RESET = ACT_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_INPUT   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_STATES = CFG_IDX_BITS'(1);

    localparam logic [CIDX_BITS-1:0] BD0_BASE = CIDX_BITS'(STATES * STATES);
    localparam logic [CIDX_BITS-1:0] BD1_BASE = CIDX_BITS'(STATES * STATES + STATES);
    localparam logic [CIDX_BITS-1:0] C_BASE   = CIDX_BITS'(STATES * STATES + 2 * STATES);
    localparam logic [CIDX_BITS-1:0] D_INDEX  = CIDX_BITS'(STATES * STATES + 3 * STATES);

    localparam logic signed [ACC_BITS-1:0]    RND_BIAS   = ACC_BITS'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [STATE_BITS-1:0]  STATE_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0]  STATE_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [OP_BITS-1:0] {
        OP_SAMPLE = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        OPND_X     = 4'b0001,
        OPND_NX    = 4'b0010,
        OPND_UPREV = 4'b0100,
        OPND_U     = 4'b1000
    } t_opnd;

    typedef struct packed {
        logic                 issue;
        logic [CIDX_BITS-1:0] coef_idx;
        t_opnd                opnd;
        logic [ROW_BITS-1:0]  st_idx;
        logic                 hi_half;
        logic                 first;
        logic                 last;
        logic                 to_out;
        logic [ROW_BITS-1:0]  dst_row;
        logic                 wr_coef;
        logic                 clear;
        logic                 load_u;
        logic                 commit;
        logic [ROW_BITS-1:0]  k_m1;
    } t_ssf_cmd;

    typedef struct packed {
        logic busy;
        logic out_full;
    } t_ssf_sts;

endpackage

FILE: sv/ssf_dp.sv
module ssf_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ssf_pkg::t_ssf_cmd                      i_cmd,
    output ssf_pkg::t_ssf_sts                      o_sts,
    input  logic        [ssf_pkg::CIDX_BITS-1:0]   i_coef_index,
    input  logic signed [ssf_pkg::CVAL_BITS-1:0]   i_coef_value,
    input  logic signed [ssf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic signed [ssf_pkg::INIT_BITS-1:0]   i_init_input,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [ssf_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic                                   o_saturated
);

    logic signed [ssf_pkg::COEF_BITS-1:0]   r_coef [ssf_pkg::TABLE_SIZE];
    logic signed [ssf_pkg::STATE_BITS-1:0]  r_x    [ssf_pkg::STATES];
    logic signed [ssf_pkg::STATE_BITS-1:0]  r_nx   [ssf_pkg::STATES];
    logic signed [ssf_pkg::SAMPLE_BITS-1:0] r_u;
    logic signed [ssf_pkg::SAMPLE_BITS-1:0] r_uprev;

    logic signed [ssf_pkg::STATE_BITS-1:0] w_sel;
    logic signed [ssf_pkg::OPND_BITS-1:0]  w_opnd;
    logic signed [ssf_pkg::COEF_BITS-1:0]  w_coef;
    logic signed [ssf_pkg::PROD_BITS-1:0]  w_prod;

    logic signed [ssf_pkg::PROD_BITS-1:0] r_prod;
    logic                                 r_p_vld;
    logic                                 r_p_hi;
    logic                                 r_p_first;
    logic                                 r_p_last;
    logic                                 r_p_out;
    logic        [ssf_pkg::ROW_BITS-1:0]  r_p_row;

    logic signed [ssf_pkg::ACC_BITS-1:0] w_addend;
    logic signed [ssf_pkg::ACC_BITS-1:0] r_acc;
    logic                                r_a_last;
    logic                                r_a_out;
    logic        [ssf_pkg::ROW_BITS-1:0] r_a_row;

    logic signed [ssf_pkg::ACC_BITS-1:0]    w_rnd;
    logic signed [ssf_pkg::SH_BITS-1:0]     w_sh;
    logic        [ssf_pkg::SH_BITS-ssf_pkg::STATE_BITS:0]  w_st_top;
    logic        [ssf_pkg::SH_BITS-ssf_pkg::SAMPLE_BITS:0] w_out_top;
    logic                                   w_st_fit;
    logic                                   w_out_fit;
    logic signed [ssf_pkg::STATE_BITS-1:0]  w_st_val;
    logic signed [ssf_pkg::SAMPLE_BITS-1:0] w_out_val;

    logic signed [ssf_pkg::SAMPLE_BITS-1:0] r_out;
    logic                                   r_sat;
    logic                                   r_out_vld;

    // coefficient table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssf_pkg::TABLE_SIZE; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cmd.wr_coef
                     && (i_coef_index < ssf_pkg::CIDX_BITS'(ssf_pkg::TABLE_SIZE))) begin
            r_coef[i_coef_index] <= ssf_pkg::COEF_BITS'(i_coef_value);
        end
    end

    // state vector and previous input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssf_pkg::STATES; i++) begin
                r_x[i] <= '0;
            end
            r_uprev <= '0;
        end else if (i_cmd.clear) begin
            for (int i = 0; i < ssf_pkg::STATES; i++) begin
                r_x[i] <= '0;
            end
            r_uprev <= ssf_pkg::SAMPLE_BITS'(i_init_input);
        end else if (i_cmd.commit) begin
            for (int i = 0; i < ssf_pkg::STATES; i++) begin
                if (ssf_pkg::ROW_BITS'(i) <= i_cmd.k_m1) begin
                    r_x[i] <= r_nx[i];
                end
            end
            r_uprev <= r_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_u) begin
            r_u <= i_sample;
        end
    end

    // operand select and multiply
    always_comb begin
        w_sel  = (i_cmd.opnd == ssf_pkg::OPND_NX) ? r_nx[i_cmd.st_idx] : r_x[i_cmd.st_idx];
        w_coef = r_coef[i_cmd.coef_idx];
        unique case (i_cmd.opnd)
            ssf_pkg::OPND_X, ssf_pkg::OPND_NX: begin
                if (i_cmd.hi_half) begin
                    w_opnd = ssf_pkg::OPND_BITS'(
                        $signed(w_sel[ssf_pkg::STATE_BITS-1:ssf_pkg::HALF_BITS]));
                end else begin
                    w_opnd = ssf_pkg::OPND_BITS'(
                        $signed({1'b0, w_sel[ssf_pkg::HALF_BITS-1:0]}));
                end
            end
            ssf_pkg::OPND_UPREV: w_opnd = ssf_pkg::OPND_BITS'(r_uprev);
            ssf_pkg::OPND_U:     w_opnd = ssf_pkg::OPND_BITS'(r_u);
            default:             w_opnd = '0;
        endcase
        w_prod = w_coef * w_opnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_prod    <= w_prod;
            r_p_hi    <= i_cmd.hi_half;
            r_p_first <= i_cmd.first;
            r_p_last  <= i_cmd.last;
            r_p_out   <= i_cmd.to_out;
            r_p_row   <= i_cmd.dst_row;
        end
    end

    // accumulate
    assign w_addend = r_p_hi ? (ssf_pkg::ACC_BITS'(r_prod) <<< ssf_pkg::HALF_BITS)
                             : ssf_pkg::ACC_BITS'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_last <= 1'b0;
        end else begin
            r_a_last <= r_p_vld & r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_acc   <= r_p_first ? w_addend : r_acc + w_addend;
            r_a_out <= r_p_out;
            r_a_row <= r_p_row;
        end
    end

    // round, shift and saturate
    always_comb begin
        w_rnd     = r_acc + ssf_pkg::RND_BIAS;
        w_sh      = $signed(w_rnd[ssf_pkg::ACC_BITS-1:ssf_pkg::FRAC_SHIFT]);
        w_st_top  = w_sh[ssf_pkg::SH_BITS-1:ssf_pkg::STATE_BITS-1];
        w_out_top = w_sh[ssf_pkg::SH_BITS-1:ssf_pkg::SAMPLE_BITS-1];
        w_st_fit  = (&w_st_top) | ~(|w_st_top);
        w_out_fit = (&w_out_top) | ~(|w_out_top);
        if (w_st_fit) begin
            w_st_val = w_sh[ssf_pkg::STATE_BITS-1:0];
        end else begin
            w_st_val = w_sh[ssf_pkg::SH_BITS-1] ? ssf_pkg::STATE_MIN : ssf_pkg::STATE_MAX;
        end
        if (w_out_fit) begin
            w_out_val = w_sh[ssf_pkg::SAMPLE_BITS-1:0];
        end else begin
            w_out_val = w_sh[ssf_pkg::SH_BITS-1] ? ssf_pkg::SAMPLE_MIN : ssf_pkg::SAMPLE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_last && !r_a_out) begin
            r_nx[r_a_row] <= w_st_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_last && r_a_out) begin
            r_out <= w_out_val;
            r_sat <= ~w_out_fit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_a_last && r_a_out) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_sts.busy     = r_p_vld | r_a_last;
    assign o_sts.out_full = r_out_vld;
    assign o_out_valid    = r_out_vld;
    assign o_out_sample   = r_out;
    assign o_saturated    = r_sat;

endmodule

FILE: sv/ssf_ctrl.sv
module ssf_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ssf_pkg::OP_BITS-1:0]    i_op,
    input  logic [ssf_pkg::ACT_BITS-1:0]   i_active,
    input  ssf_pkg::t_ssf_sts              i_sts,
    output ssf_pkg::t_ssf_cmd              o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROW  = 5'b00010,
        S_WAIT = 5'b00100,
        S_OUT  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        PH_X     = 3'b001,
        PH_TAIL1 = 3'b010,
        PH_TAIL2 = 3'b100
    } t_phase;

    t_state                        r_state, n_state;
    t_phase                        r_ph, n_ph;
    logic [ssf_pkg::ROW_BITS-1:0]  r_row, n_row;
    logic [ssf_pkg::ROW_BITS-1:0]  r_col, n_col;
    logic                          r_hi, n_hi;
    logic [ssf_pkg::ROW_BITS-1:0]  w_k_m1;
    logic                          w_accept;

    // active count clamped into one to the built count
    always_comb begin
        priority if (i_active == '0) begin
            w_k_m1 = '0;
        end else if (i_active > ssf_pkg::ACT_BITS'(ssf_pkg::STATES)) begin
            w_k_m1 = ssf_pkg::ROW_BITS'(ssf_pkg::STATES - 1);
        end else begin
            w_k_m1 = ssf_pkg::ROW_BITS'(i_active - 1'b1);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_row   = r_row;
        n_col   = r_col;
        n_hi    = r_hi;
        o_cmd       = '0;
        o_cmd.opnd  = ssf_pkg::OPND_X;
        o_cmd.k_m1  = w_k_m1;
        o_cmd.first = (r_ph == PH_X) && (r_col == '0) && !r_hi;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (ssf_pkg::t_op'(i_op))
                        ssf_pkg::OP_SAMPLE: begin
                            o_cmd.load_u = 1'b1;
                            n_state      = S_ROW;
                            n_ph         = PH_X;
                            n_row        = '0;
                            n_col        = '0;
                            n_hi         = 1'b0;
                        end
                        ssf_pkg::OP_WRITE: o_cmd.wr_coef = 1'b1;
                        ssf_pkg::OP_CLEAR: o_cmd.clear   = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_ROW: begin
                o_cmd.issue   = 1'b1;
                o_cmd.dst_row = r_row;
                unique case (r_ph)
                    PH_X: begin
                        o_cmd.coef_idx = ssf_pkg::CIDX_BITS'(r_row)
                                         * ssf_pkg::CIDX_BITS'(ssf_pkg::STATES)
                                         + ssf_pkg::CIDX_BITS'(r_col);
                        o_cmd.opnd     = ssf_pkg::OPND_X;
                        o_cmd.st_idx   = r_col;
                        o_cmd.hi_half  = r_hi;
                        n_hi           = ~r_hi;
                        if (r_hi) begin
                            if (r_col == w_k_m1) begin
                                n_ph = PH_TAIL1;
                            end else begin
                                n_col = ssf_pkg::ROW_BITS'(r_col + 1'b1);
                            end
                        end
                    end
                    PH_TAIL1: begin
                        o_cmd.coef_idx = ssf_pkg::BD0_BASE + ssf_pkg::CIDX_BITS'(r_row);
                        o_cmd.opnd     = ssf_pkg::OPND_UPREV;
                        n_ph           = PH_TAIL2;
                    end
                    PH_TAIL2: begin
                        o_cmd.coef_idx = ssf_pkg::BD1_BASE + ssf_pkg::CIDX_BITS'(r_row);
                        o_cmd.opnd     = ssf_pkg::OPND_U;
                        o_cmd.last     = 1'b1;
                        if (r_row == w_k_m1) begin
                            n_state = S_WAIT;
                        end else begin
                            n_row = ssf_pkg::ROW_BITS'(r_row + 1'b1);
                            n_col = '0;
                            n_hi  = 1'b0;
                            n_ph  = PH_X;
                        end
                    end
                    default: n_ph = PH_X;
                endcase
            end
            S_WAIT: begin
                if (!i_sts.busy && !i_sts.out_full) begin
                    n_state = S_OUT;
                    n_ph    = PH_X;
                    n_col   = '0;
                    n_hi    = 1'b0;
                end
            end
            S_OUT: begin
                o_cmd.issue  = 1'b1;
                o_cmd.to_out = 1'b1;
                unique case (r_ph)
                    PH_X: begin
                        o_cmd.coef_idx = ssf_pkg::C_BASE + ssf_pkg::CIDX_BITS'(r_col);
                        o_cmd.opnd     = ssf_pkg::OPND_NX;
                        o_cmd.st_idx   = r_col;
                        o_cmd.hi_half  = r_hi;
                        n_hi           = ~r_hi;
                        if (r_hi) begin
                            if (r_col == w_k_m1) begin
                                n_ph = PH_TAIL1;
                            end else begin
                                n_col = ssf_pkg::ROW_BITS'(r_col + 1'b1);
                            end
                        end
                    end
                    PH_TAIL1: begin
                        o_cmd.coef_idx = ssf_pkg::D_INDEX;
                        o_cmd.opnd     = ssf_pkg::OPND_U;
                        o_cmd.last     = 1'b1;
                        n_state        = S_FIN;
                    end
                    default: begin
                        o_cmd.issue = 1'b0;
                        n_ph        = PH_X;
                    end
                endcase
            end
            S_FIN: begin
                if (!i_sts.busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_X;
            r_row   <= '0;
            r_col   <= '0;
            r_hi    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_row   <= n_row;
            r_col   <= n_col;
            r_hi    <= n_hi;
        end
    end

endmodule

FILE: sv/state_space_filter_step_top.sv
// sample: one shared 32x25 multiply-accumulate walks k*(2k+2) state-update terms, then
// 2k+1 output terms (each 48-bit state taken as two halves); the output terms wait
// until the previous result has been taken
// input is stalled while a sample runs
// synchronous active-low reset clears state, previous input and coefficient table,
// sets initial input to 0 and active states to 4
module state_space_filter_step_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic        [ssf_pkg::OP_BITS-1:0]       i_op,
    input  logic        [ssf_pkg::CIDX_BITS-1:0]     i_coef_index,
    input  logic signed [ssf_pkg::CVAL_BITS-1:0]     i_coef_value,
    input  logic signed [ssf_pkg::SAMPLE_BITS-1:0]   i_sample,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [ssf_pkg::SAMPLE_BITS-1:0]   o_out_sample,
    output logic                                     o_saturated,
    input  logic                                     i_cfg_we,
    input  logic        [ssf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic        [ssf_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    logic signed [ssf_pkg::INIT_BITS-1:0] r_init_input;
    logic        [ssf_pkg::ACT_BITS-1:0]  r_active;
    ssf_pkg::t_ssf_cmd                    w_cmd;
    ssf_pkg::t_ssf_sts                    w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_input <= '0;
            r_active     <= ssf_pkg::ACT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssf_pkg::CFG_INIT_INPUT:
                    r_init_input <= $signed(i_cfg_data[ssf_pkg::INIT_BITS-1:0]);
                ssf_pkg::CFG_ACTIVE_STATES:
                    r_active <= i_cfg_data[ssf_pkg::ACT_BITS-1:0];
                default: ;
            endcase
        end
    end

    ssf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_active   (r_active),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ssf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_sample     (i_sample),
        .i_init_input (r_init_input),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample),
        .o_saturated  (o_saturated)
    );

`ifndef SYNTHESIS
    a_issue_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> o_in_stall)
        else $error("term issued while input side open");

    a_commit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !w_sts.busy)
        else $error("state commit with terms in flight");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_sts.busy)
        else $error("mac pipeline busy while idle");

    a_result_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_stall)
        else $error("result appeared outside sample processing");
`endif

endmodule
